### hdl/ssi_pkg.sv
`default_nettype none

package ssi_pkg;

   // list geometry
   localparam int CAPACITY = 64;
   localparam int RANK_W   = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);

   // port widths fixed by the interface
   localparam int OPC_W    = 2;
   localparam int RIDX_W   = 6;
   localparam int OCNT_W   = 7;
   localparam int STAT_W   = 2;

   // opcodes
   localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPC_W-1:0] OP_READ   = 2'd1;
   localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_DUP   = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

   // command broadcast to every cell
   typedef struct packed {
      logic              write_en;
      logic [RANK_W-1:0] value;
   } cell_cmd_type;

endpackage

`default_nettype wire

### hdl/ssi_cell.sv
`default_nettype none

module ssi_cell (
   input  wire                          clock,
   input  wire ssi_pkg::cell_cmd_type   cmd,
   input  wire                          in_use,
   input  wire                          left_less,
   input  wire  [ssi_pkg::RANK_W-1:0]   left_entry,
   output logic [ssi_pkg::RANK_W-1:0]   entry,
   output logic                         less,
   output logic                         equal
);
   import ssi_pkg::*;

   logic [RANK_W-1:0] entry_ff;
   logic [RANK_W-1:0] entry_in;

   // compare the held entry against the broadcast value
   assign less  = in_use && (entry_ff < cmd.value);
   assign equal = in_use && (entry_ff == cmd.value);
   assign entry = entry_ff;

   // hold below the insert point, take the value at it, shift up above it
   always_comb begin
      entry_in = entry_ff;
      if (cmd.write_en && !less) begin
         if (left_less) begin
            entry_in = cmd.value;
         end else begin
            entry_in = left_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

### hdl/sorted_unique_set_insert.sv
// Sorted unique set: keeps an ascending list of up to 64 distinct 32-bit rank
// numbers in a row of cells. Each beat on the req_ channel is an insert, a read
// or a clear (opcode 3 is a no-op), and yields exactly one beat on the rsp_
// channel, registered in the cycle after acceptance. One item is taken every
// cycle unless the output is stalled: every cell compares its entry with the
// incoming value at once and either holds, takes the value or takes its left
// neighbor's entry, so an insert finishes in the cycle it is accepted. A new
// item is accepted while the output register is empty or is being drained.
// No clearing pass runs after reset; entries above the count are never read.
`default_nettype none

module sorted_unique_set_insert (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [ssi_pkg::OPC_W-1:0]    req_opcode,
   input  wire  [ssi_pkg::RANK_W-1:0]   req_rank_value,
   input  wire  [ssi_pkg::RIDX_W-1:0]   req_read_index,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [ssi_pkg::RANK_W-1:0]   rsp_read_value,
   output logic [ssi_pkg::OCNT_W-1:0]   rsp_entry_count,
   output logic [ssi_pkg::STAT_W-1:0]   rsp_status
);
   import ssi_pkg::*;

   logic                 req_accept;
   logic                 is_insert;
   logic                 is_read;
   logic                 is_clear;
   logic                 dup_hit;
   logic                 list_full;
   logic                 read_ok;
   logic [IDX_W-1:0]     sel_idx;
   cell_cmd_type         cmd;

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [RANK_W-1:0]    read_value_ff;
   logic [RANK_W-1:0]    read_value_in;
   logic [OCNT_W-1:0]    entry_count_ff;
   logic [STAT_W-1:0]    status_ff;
   logic [STAT_W-1:0]    status_in;

   logic [CAPACITY-1:0]  in_use_vec;
   logic [CAPACITY-1:0]  less_vec;
   logic [CAPACITY-1:0]  equal_vec;
   logic [RANK_W-1:0]    entry_arr [CAPACITY];

   // accept while the output register is free or draining
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign is_insert = (req_opcode == OP_INSERT);
   assign is_read   = (req_opcode == OP_READ);
   assign is_clear  = (req_opcode == OP_CLEAR);
   assign dup_hit   = |equal_vec;
   assign list_full = (count_ff >= CNT_W'(CAPACITY));

   assign cmd.write_en = req_accept && is_insert && !dup_hit && !list_full;
   assign cmd.value    = req_rank_value;

   // row of cells, chained from index zero upward
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign in_use_vec[i] = (CNT_W'(i) < count_ff);
      if (i == 0) begin : g_first
         ssi_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .in_use     (in_use_vec[i]),
            .left_less  (1'b1),
            .left_entry (req_rank_value),
            .entry      (entry_arr[i]),
            .less       (less_vec[i]),
            .equal      (equal_vec[i])
         );
      end else begin : g_next
         ssi_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .in_use     (in_use_vec[i]),
            .left_less  (less_vec[i-1]),
            .left_entry (entry_arr[i-1]),
            .entry      (entry_arr[i]),
            .less       (less_vec[i]),
            .equal      (equal_vec[i])
         );
      end
   end

   // read select
   assign sel_idx = IDX_W'(req_read_index);
   assign read_ok = (32'(req_read_index) < 32'(count_ff));

   // next count
   always_comb begin
      count_in = count_ff;
      if (req_accept && is_clear) begin
         count_in = '0;
      end else if (cmd.write_en) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // result fields
   always_comb begin
      read_value_in = '0;
      status_in     = ST_DONE;
      if (is_insert) begin
         if (dup_hit) begin
            status_in = ST_DUP;
         end else if (list_full) begin
            status_in = ST_FULL;
         end
      end else if (is_read) begin
         if (read_ok) begin
            read_value_in = entry_arr[sel_idx];
         end else begin
            status_in = ST_RANGE;
         end
      end
   end

   // output beat valid: load on accept, hold while stalled, drop when taken
   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         read_value_ff  <= read_value_in;
         entry_count_ff <= OCNT_W'(count_in);
         status_ff      <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_entry_count = entry_count_ff;
   assign rsp_status      = status_ff;

   // count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // a stored insert grows the list by one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.write_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not advance the count");

   // the list stays sorted: entries below the value form a prefix
   a_less_prefix: assert property (@(posedge clock) disable iff (reset)
      (less_vec & (less_vec + CAPACITY'(1))) == '0)
      else $error("less flags not a prefix");

   // entries are unique
   a_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(equal_vec))
      else $error("value held twice");

   // the reported count matches the held count
   a_count_report: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_entry_count == OCNT_W'(count_ff))
      else $error("reported count mismatch");

endmodule

`default_nettype wire

### tb/tb_sorted_unique_set_insert.sv
`default_nettype none

module tb_sorted_unique_set_insert;
   timeunit 1ns;
   timeprecision 1ps;

   import ssi_pkg::*;

   // the one opcode the block treats as a no-op
   localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [RANK_W-1:0] read_value;
      logic [OCNT_W-1:0] entry_count;
      logic [STAT_W-1:0] status;
   } set_rsp_type;

   typedef struct packed {
      logic [OPC_W-1:0]  opcode;
      logic [RANK_W-1:0] rank_value;
      logic [RIDX_W-1:0] read_index;
      logic              typed;
      logic [RANK_W-1:0] exp_value;
      logic [OCNT_W-1:0] exp_count;
      logic [STAT_W-1:0] exp_status;
   } stim_row_type;

   localparam int NUM_DIRECTED = 23;

   // directed rows; the expectation is typed in only where it is obvious
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{OP_READ,   32'hDEADBEEF, 6'd0,  1'b1, 32'd0, 7'd0, ST_RANGE},
      '{OP_INSERT, 32'h00000000, 6'd63, 1'b1, 32'd0, 7'd1, ST_DONE},
      '{OP_INSERT, 32'hFFFFFFFF, 6'd0,  1'b1, 32'd0, 7'd2, ST_DONE},
      '{OP_INSERT, 32'h00000000, 6'd21, 1'b1, 32'd0, 7'd2, ST_DUP},
      '{OP_INSERT, 32'hFFFFFFFF, 6'd42, 1'b1, 32'd0, 7'd2, ST_DUP},
      '{OP_READ,   32'hFFFFFFFF, 6'd0,  1'b0, 32'd0, 7'd0, ST_DONE},
      '{OP_READ,   32'h00000000, 6'd1,  1'b0, 32'd0, 7'd0, ST_DONE},
      '{OP_READ,   32'h12345678, 6'd2,  1'b1, 32'd0, 7'd2, ST_RANGE},
      '{OP_READ,   32'hFFFFFFFF, 6'd63, 1'b1, 32'd0, 7'd2, ST_RANGE},
      '{OP_UNUSED, 32'hFFFFFFFF, 6'd63, 1'b1, 32'd0, 7'd2, ST_DONE},
      '{OP_INSERT, 32'h80000000, 6'd0,  1'b0, 32'd0, 7'd0, ST_DONE},
      '{OP_INSERT, 32'h7FFFFFFF, 6'd0,  1'b0, 32'd0, 7'd0, ST_DONE},
      '{OP_INSERT, 32'h00000001, 6'd0,  1'b0, 32'd0, 7'd0, ST_DONE},
      '{OP_INSERT, 32'hFFFFFFFE, 6'd0,  1'b0, 32'd0, 7'd0, ST_DONE},
      '{OP_READ,   32'h00000000, 6'd1,  1'b0, 32'd0, 7'd0, ST_DONE},
      '{OP_READ,   32'h00000000, 6'd3,  1'b0, 32'd0, 7'd0, ST_DONE},
      '{OP_READ,   32'h00000000, 6'd5,  1'b0, 32'd0, 7'd0, ST_DONE},
      '{OP_CLEAR,  32'hFFFFFFFF, 6'd63, 1'b1, 32'd0, 7'd0, ST_DONE},
      '{OP_READ,   32'h00000000, 6'd0,  1'b1, 32'd0, 7'd0, ST_RANGE},
      '{OP_INSERT, 32'hAAAAAAAA, 6'd0,  1'b1, 32'd0, 7'd1, ST_DONE},
      '{OP_INSERT, 32'h55555555, 6'd0,  1'b0, 32'd0, 7'd0, ST_DONE},
      '{OP_READ,   32'h00000000, 6'd0,  1'b0, 32'd0, 7'd0, ST_DONE},
      '{OP_CLEAR,  32'h00000000, 6'd0,  1'b1, 32'd0, 7'd0, ST_DONE}
   };

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [OPC_W-1:0]  req_opcode;
   logic [RANK_W-1:0] req_rank_value;
   logic [RIDX_W-1:0] req_read_index;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [RANK_W-1:0] rsp_read_value;
   logic [OCNT_W-1:0] rsp_entry_count;
   logic [STAT_W-1:0] rsp_status;

   // shadow copy of the set
   logic [RANK_W-1:0] set_entries [CAPACITY];
   int                set_count;

   set_rsp_type pending_results [$];
   int          mismatch_count;
   int          beats_sent;
   int          beats_seen;
   int          status_tally [4];
   int          peak_count;
   int          idle_pct;
   int          stall_pct;

   sorted_unique_set_insert dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_rank_value  (req_rank_value),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // hard stop far beyond the slowest correct run
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic note_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // apply one beat to the shadow set and return the result it should give
   function automatic set_rsp_type apply_to_set(input logic [OPC_W-1:0] opcode,
                                                input logic [RANK_W-1:0] value,
                                                input logic [RIDX_W-1:0] index);
      set_rsp_type res;
      int          pos;
      res = '0;
      res.status = ST_DONE;
      case (opcode)
         OP_INSERT: begin
            pos = 0;
            for (int i = 0; i < set_count; i++)
               if (set_entries[i] < value) pos++;
            if (pos < set_count && set_entries[pos] == value) begin
               res.status = ST_DUP;
            end else if (set_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (int i = set_count; i > pos; i--)
                  set_entries[i] = set_entries[i-1];
               set_entries[pos] = value;
               set_count++;
            end
         end
         OP_READ: begin
            if (int'(index) < set_count) res.read_value = set_entries[index];
            else res.status = ST_RANGE;
         end
         OP_CLEAR: set_count = 0;
         default: ;
      endcase
      res.entry_count = set_count[OCNT_W-1:0];
      return res;
   endfunction

   // offer one beat after a random gap, hold it until taken, then predict
   task automatic issue_beat(input stim_row_type row);
      set_rsp_type exp;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= row.opcode;
      req_rank_value <= row.rank_value;
      req_read_index <= row.read_index;
      do @(posedge clock); while (req_stall);
      exp = apply_to_set(row.opcode, row.rank_value, row.read_index);
      if (row.typed) begin
         exp.read_value  = row.exp_value;
         exp.entry_count = row.exp_count;
         exp.status      = row.exp_status;
      end
      pending_results = {pending_results, exp};
      beats_sent++;
      if (set_count > peak_count) peak_count = set_count;
      @(negedge clock);
   endtask

   // hold the sender off until every outstanding result has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // one stretch from an empty set: mostly inserts, so the set fills and overflows
   task automatic run_episode(input int n_items);
      stim_row_type row;
      int           pick;
      int           k;
      row = '0;
      row.opcode     = OP_CLEAR;
      row.rank_value = $urandom;
      row.read_index = $urandom_range(63);
      issue_beat(row);
      for (int n = 0; n < n_items; n++) begin
         row = '0;
         row.rank_value = $urandom;
         row.read_index = $urandom_range(63);
         pick = $urandom_range(99);
         if (pick < 60) begin
            row.opcode = OP_INSERT;
            pick = $urandom_range(9);
            if (set_count > 0 && (pick == 6 || pick == 7)) begin
               // duplicate of a held value
               row.rank_value = set_entries[$urandom_range(set_count - 1)];
            end else if (set_count > 0 && pick == 9) begin
               // neighbor of a held value
               k = $urandom_range(set_count - 1);
               row.rank_value = $urandom_range(1) ? set_entries[k] + 32'd1
                                                  : set_entries[k] - 32'd1;
            end else if (pick == 8) begin
               case ($urandom_range(2))
                  0: row.rank_value = 32'h00000000;
                  1: row.rank_value = 32'hFFFFFFFF;
                  default: row.rank_value = $urandom_range(15);
               endcase
            end
         end else if (pick < 92) begin
            row.opcode = OP_READ;
            if (set_count > 0 && $urandom_range(3) != 0)
               row.read_index = $urandom_range(set_count - 1);
         end else if (pick < 93) begin
            row.opcode = OP_CLEAR;
         end else begin
            row.opcode = OP_UNUSED;
         end
         issue_beat(row);
      end
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
   end

   // compare every accepted result beat with the oldest expectation
   always @(posedge clock) begin
      set_rsp_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         status_tally[rsp_status]++;
         if (pending_results.size() == 0) begin
            note_mismatch("result beat with nothing expected");
         end else begin
            exp = pending_results.pop_front();
            if (rsp_read_value !== exp.read_value)
               note_mismatch($sformatf("beat %0d read_value %h, want %h",
                             beats_seen, rsp_read_value, exp.read_value));
            if (rsp_entry_count !== exp.entry_count)
               note_mismatch($sformatf("beat %0d entry_count %0d, want %0d",
                             beats_seen, rsp_entry_count, exp.entry_count));
            if (rsp_status !== exp.status)
               note_mismatch($sformatf("beat %0d status %0d, want %0d",
                             beats_seen, rsp_status, exp.status));
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_opcode     = OP_INSERT;
      req_rank_value = '0;
      req_read_index = '0;
      rsp_stall      = 1'b0;
      set_count      = 0;
      mismatch_count = 0;
      beats_sent     = 0;
      beats_seen     = 0;
      peak_count     = 0;
      idle_pct       = 0;
      stall_pct      = 0;
      for (int s = 0; s < 4; s++) status_tally[s] = 0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows, no back-pressure
      for (int i = 0; i < NUM_DIRECTED; i++) issue_beat(directed_rows[i]);
      drain_results();

      // random episodes under each idling mix
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 76; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 76; end
            default: begin idle_pct = 26; stall_pct = 26; end
         endcase
         run_episode(190);
         run_episode(190);
         drain_results();
      end

      stall_pct = 0;
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0)
         note_mismatch($sformatf("%0d expected results never arrived",
                       pending_results.size()));

      $display("Covered %0d beats in, %0d out; peak set size %0d of %0d",
               beats_sent, beats_seen, peak_count, CAPACITY);
      $display("Status mix: done %0d, duplicate %0d, full %0d, out of range %0d",
               status_tally[ST_DONE], status_tally[ST_DUP],
               status_tally[ST_FULL], status_tally[ST_RANGE]);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sorted_unique_set_insert.f
hdl/ssi_pkg.sv
hdl/ssi_cell.sv
hdl/sorted_unique_set_insert.sv
tb/tb_sorted_unique_set_insert.sv
